// ===== rtl/timer_expiry_queue_core_assert.svh =====
// Assertion macros for the timer expiry queue
`ifndef TIMER_EXPIRY_QUEUE_CORE_ASSERT_SVH
`define TIMER_EXPIRY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define TEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define TEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/teq_pkg.sv =====
// Shared types and constants of the timer expiry queue
package teq_pkg;
	localparam int unsigned TIMER_SLOTS_DEF = 16;
	localparam int unsigned MAX_FIRES = 16;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned ID_W = 32;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ADDED = 3'd0,
		KIND_FULL = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_FIRED = 3'd4,
		KIND_NONE_FIRED = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_RESCAN,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item, clear scan
		logic scan_step; // examine one slot
		logic act;       // apply result of scan
		logic last_fix;  // end of look-ahead scan: settle last flag
	} teq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic more;      // tick: another fire may follow
		logic ignore;    // unused command
	} teq_sts_t;
endpackage

// ===== rtl/timer_expiry_queue_core.sv =====
// Top level of the timer expiry queue
// Timer table of TIMER_SLOTS entries, scanned one slot a cycle through a single
// comparator with registered table reads. An add or cancel runs the scan, a table
// update, offering the result and an idle state before the earliest next transfer
// in. An unused command returns to idle and gives no result. A tick scans the whole
// table once and then, per fired timer (at most MAX_FIRES), spends a table update,
// a full look-ahead scan that tells whether another fire follows (left out at the
// fire limit) and then offers the result; a tick that fires nothing offers only a
// none-fired result. A result waits in the output register until transferred; the
// next item is taken after the last result.
module timer_expiry_queue_core import teq_pkg::*; #(
	parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [ID_W-1:0]   delay_ms,
	input  logic [ID_W-1:0]   period_ms,
	input  logic [ID_W-1:0]   cancel_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        kind,
	output logic [ID_W-1:0]   timer_id,
	output logic [ID_W-1:0]   rearm_id,
	output logic              last
);
`include "timer_expiry_queue_core_assert.svh"
	teq_cmd_t ctl;
	teq_sts_t sts;

	teq_datapath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
		.clk, .arst_n, .ctl, .sts, .command, .now_ms, .delay_ms, .period_ms,
		.cancel_id, .kind, .timer_id, .rearm_id, .last
	);

	teq_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts,
		.dp_last(last), .ctl
	);

	`TEQ_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, in_stall)
	`TEQ_ASSERT_NEXT(a_load_scan, clk, arst_n, in_valid && !in_stall, !out_valid)
endmodule

// ===== rtl/teq_datapath.sv =====
// Timer table, slot scanner and result register
module teq_datapath import teq_pkg::*; #(
	parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  teq_cmd_t             ctl,
	output teq_sts_t             sts,
	input  logic [1:0]           command,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic [ID_W-1:0]      delay_ms,
	input  logic [ID_W-1:0]      period_ms,
	input  logic [ID_W-1:0]      cancel_id,
	output logic [2:0]           kind,
	output logic [ID_W-1:0]      timer_id,
	output logic [ID_W-1:0]      rearm_id,
	output logic                 last
);
	localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
	localparam int unsigned FW = $clog2(MAX_FIRES + 1);

	logic [TIMER_SLOTS-1:0] valid_q, done_q;
	logic [ID_W-1:0]   id_mem [TIMER_SLOTS];
	logic [TIME_W-1:0] exp_mem [TIMER_SLOTS];
	logic [ID_W-1:0]   per_mem [TIMER_SLOTS];
	logic [ID_W-1:0]   id_ctr_q;

	logic [1:0]        cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [ID_W-1:0]   delay_q, period_q, cid_q;
	logic [CW-1:0]     idx_q;
	logic              found_q;
	logic [IW-1:0]     best_q;
	logic [TIME_W-1:0] best_exp_q;
	logic [ID_W-1:0]   best_id_q, best_per_q;
	logic [FW-1:0]     nfire_q;
	logic [ID_W-1:0]   rd_id_q, rd_per_q;
	logic [TIME_W-1:0] rd_exp_q;

	logic [IW-1:0]     idx, rd_idx;
	logic [CW-1:0]     idx_d;
	logic [ID_W-1:0]   next_id, id_inc;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] sat;
	logic              cand, better, take;

	assign idx = idx_q[IW-1:0];
	assign id_inc = id_ctr_q + 1'b1;
	assign next_id = (id_inc == '0) ? {{(ID_W-1){1'b0}}, 1'b1} : id_inc;

	// table read is registered: fetch the slot the next cycle will examine
	always_comb begin
		if (ctl.load || ctl.act)
			idx_d = '0;
		else if (ctl.scan_step)
			idx_d = idx_q + 1'b1;
		else
			idx_d = idx_q;
	end
	assign rd_idx = idx_d[IW-1:0];

	always_comb begin
		cand = 1'b0;
		better = 1'b0;
		case (cmd_t'(cmd_q))
			CMD_ADD: cand = !valid_q[idx];
			CMD_CANCEL: cand = valid_q[idx] && rd_id_q == cid_q;
			CMD_TICK: begin
				cand = valid_q[idx] && !done_q[idx] && rd_exp_q <= now_q;
				better = rd_exp_q < best_exp_q ||
					(rd_exp_q == best_exp_q && rd_id_q < best_id_q);
			end
			default: cand = 1'b0;
		endcase
	end

	assign take = ctl.scan_step && cand &&
		(!found_q || (cmd_t'(cmd_q) == CMD_TICK && better));

	// saturating expiry for add or re-arm
	always_comb begin
		if (cmd_t'(cmd_q) == CMD_ADD)
			sum = {1'b0, now_q} + {{(TIME_W-ID_W+1){1'b0}}, delay_q};
		else
			sum = {1'b0, now_q} + {{(TIME_W-ID_W+1){1'b0}}, best_per_q};
		sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	end

	assign sts.scan_done = (idx_q == CW'(TIMER_SLOTS - 1)) ||
		(found_q && cmd_t'(cmd_q) != CMD_TICK) ||
		(cand && cmd_t'(cmd_q) != CMD_TICK);
	assign sts.more = found_q && cmd_t'(cmd_q) == CMD_TICK &&
		nfire_q != FW'(MAX_FIRES - 1);
	assign sts.ignore = cmd_t'(cmd_q) == CMD_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q <= '0;
			id_ctr_q <= '0;
			cmd_q <= CMD_NONE;
			idx_q <= '0;
			found_q <= 1'b0;
			nfire_q <= '0;
		end else begin
			idx_q <= idx_d;
			if (ctl.load) begin
				cmd_q <= command;
				done_q <= '0;
				found_q <= 1'b0;
				nfire_q <= '0;
			end
			if (take)
				found_q <= 1'b1;
			if (ctl.act) begin
				found_q <= 1'b0;
				case (cmd_t'(cmd_q))
					CMD_ADD: if (found_q) begin
						valid_q[best_q] <= 1'b1;
						id_ctr_q <= next_id;
					end
					CMD_CANCEL: if (found_q) valid_q[best_q] <= 1'b0;
					CMD_TICK: if (found_q) begin
						done_q[best_q] <= 1'b1;
						nfire_q <= nfire_q + 1'b1;
						if (best_per_q != '0) id_ctr_q <= next_id;
						else valid_q[best_q] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_id_q <= id_mem[rd_idx];
		rd_exp_q <= exp_mem[rd_idx];
		rd_per_q <= per_mem[rd_idx];
		if (ctl.load) begin
			now_q <= now_ms;
			delay_q <= delay_ms;
			period_q <= period_ms;
			cid_q <= cancel_id;
		end
		if (take) begin
			best_q <= idx;
			best_exp_q <= rd_exp_q;
			best_id_q <= rd_id_q;
			best_per_q <= rd_per_q;
		end
		if (ctl.act) begin
			case (cmd_t'(cmd_q))
				CMD_ADD: begin
					if (found_q) begin
						id_mem[best_q] <= next_id;
						exp_mem[best_q] <= sat;
						per_mem[best_q] <= period_q;
						kind <= KIND_ADDED;
						timer_id <= next_id;
					end else begin
						kind <= KIND_FULL;
						timer_id <= '0;
					end
					rearm_id <= '0;
					last <= 1'b1;
				end
				CMD_CANCEL: begin
					kind <= found_q ? KIND_CANCELLED : KIND_NOT_FOUND;
					timer_id <= '0;
					rearm_id <= '0;
					last <= 1'b1;
				end
				default: begin
					if (found_q) begin
						kind <= KIND_FIRED;
						timer_id <= best_id_q;
						if (best_per_q != '0) begin
							id_mem[best_q] <= next_id;
							exp_mem[best_q] <= sat;
							rearm_id <= next_id;
						end else begin
							rearm_id <= '0;
						end
						// final by the fire limit; otherwise the look-ahead scan decides
						last <= (nfire_q == FW'(MAX_FIRES - 1));
					end else begin
						kind <= KIND_NONE_FIRED;
						timer_id <= '0;
						rearm_id <= '0;
						last <= 1'b1;
					end
				end
			endcase
		end
		if (ctl.last_fix) last <= !(found_q || cand);
		if (ctl.load) last <= 1'b0;
	end
endmodule

// ===== rtl/teq_ctrl.sv =====
// Sequencing controller of the timer expiry queue
module teq_ctrl import teq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  teq_sts_t sts,
	input  logic     dp_last,
	output teq_cmd_t ctl
);
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.ignore) state_d = ST_IDLE;
				else if (sts.scan_done) state_d = ST_ACT;
			end
			// after a fire below the fire limit, scan again before offering it to learn whether it is final
			ST_ACT: state_d = sts.more ? ST_RESCAN : ST_OUT;
			ST_RESCAN: if (sts.scan_done) state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = (dp_last) ? ST_IDLE : ST_ACT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			ST_SCAN: ctl.scan_step = !sts.ignore;
			ST_ACT: ctl.act = 1'b1;
			ST_RESCAN: begin
				ctl.scan_step = 1'b1;
				ctl.last_fix = sts.scan_done;
			end
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule
